### src/akf_pkg.sv
// akf_pkg: shared types, constants and saturating helpers for the altitude kalman filter
// no dependencies; used by the interfaces, the arithmetic units and the top level
package akf_pkg;

  localparam int W             = 48;
  localparam int CFG_W         = 47;
  localparam int DT_W          = 25;
  localparam int OP_W          = 2;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAC_BITS_DEF = 24;
  localparam int N_ST          = 6;
  localparam int N_AX          = 3;
  localparam int COV_DEPTH     = N_ST * N_ST;
  localparam int ADDR_W        = $clog2(COV_DEPTH);
  localparam int IDX_W         = $clog2(N_ST);

  localparam logic [CFG_W-1:0] POS_NOISE_RST = CFG_W'(167772);
  localparam logic [CFG_W-1:0] VEL_NOISE_RST = CFG_W'(1677722);
  localparam logic [CFG_W-1:0] ALT_NOISE_RST = CFG_W'(33554432);
  localparam logic [CFG_W-1:0] INIT_VAR_RST  = CFG_W'(1677722);

  localparam logic signed [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 2'd0,
    OP_PREDICT = 2'd1,
    OP_UPDATE  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_SKIPPED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_NOISE = 2'd0,
    REG_VEL_NOISE = 2'd1,
    REG_ALT_NOISE = 2'd2,
    REG_INIT_VAR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ULOAD,
    S_USUM,
    S_UCHK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EL_RDM,
    S_EL_RDX,
    S_EL_MUL,
    S_EL_WAIT,
    S_EL_WB,
    S_FINISH
  } fsm_t;

  typedef enum logic [2:0] {
    PH_PMEAN,
    PH_COVA,
    PH_COVB,
    PH_COVC,
    PH_UMEAN,
    PH_UCOV
  } phase_t;

  function automatic logic [W-1:0] mag48(input logic signed [W-1:0] x);
    logic [W-1:0] r;
    r = x[W-1] ? W'(-x) : W'(x);
    return r;
  endfunction

  // magnitude with sign to saturated signed word
  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic ovf,
                                                  input logic [W-1:0] m);
    logic signed [W-1:0] r;
    if (ovf || m[W-1]) begin
      r = neg ? MIN48 : MAX48;
    end else begin
      r = neg ? -$signed(m) : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
    logic signed [W:0] s;
    logic signed [W-1:0] r;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      r = s[W] ? MIN48 : MAX48;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

endpackage

### src/akf_in_if.sv
// akf_in_if: input channel of the altitude kalman filter, valid/ready with the item payload
// depends on akf_pkg
interface akf_in_if;
  logic                               valid;
  logic                               ready;
  logic [akf_pkg::OP_W-1:0]           operation;
  logic signed [akf_pkg::W-1:0]       init_pos_x;
  logic signed [akf_pkg::W-1:0]       init_pos_y;
  logic signed [akf_pkg::W-1:0]       init_pos_z;
  logic signed [akf_pkg::W-1:0]       init_vel_x;
  logic signed [akf_pkg::W-1:0]       init_vel_y;
  logic signed [akf_pkg::W-1:0]       init_vel_z;
  logic signed [akf_pkg::W-1:0]       accel_x;
  logic signed [akf_pkg::W-1:0]       accel_y;
  logic signed [akf_pkg::W-1:0]       accel_z;
  logic [akf_pkg::DT_W-1:0]           time_step;
  logic signed [akf_pkg::W-1:0]       altitude;

  modport source (output valid, operation, init_pos_x, init_pos_y, init_pos_z, init_vel_x,
                  init_vel_y, init_vel_z, accel_x, accel_y, accel_z, time_step, altitude,
                  input ready);
  modport sink (input valid, operation, init_pos_x, init_pos_y, init_pos_z, init_vel_x,
                init_vel_y, init_vel_z, accel_x, accel_y, accel_z, time_step, altitude,
                output ready);
endinterface

### src/akf_out_if.sv
// akf_out_if: result channel of the altitude kalman filter, valid/ready with the estimate
// depends on akf_pkg
interface akf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [akf_pkg::W-1:0]       est_pos_x;
  logic signed [akf_pkg::W-1:0]       est_pos_y;
  logic signed [akf_pkg::W-1:0]       est_pos_z;
  logic signed [akf_pkg::W-1:0]       est_vel_x;
  logic signed [akf_pkg::W-1:0]       est_vel_y;
  logic signed [akf_pkg::W-1:0]       est_vel_z;
  logic [akf_pkg::STAT_W-1:0]         status;

  modport source (output valid, est_pos_x, est_pos_y, est_pos_z, est_vel_x, est_vel_y,
                  est_vel_z, status, input ready);
  modport sink (input valid, est_pos_x, est_pos_y, est_pos_z, est_vel_x, est_vel_y,
                est_vel_z, status, output ready);
endinterface

### src/akf_mul.sv
// akf_mul: multi-cycle signed fixed-point multiplier, floor rounding, 48-bit saturation
// depends on akf_pkg; four 24x24 partial products accumulated over successive cycles
module akf_mul #(
  parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [akf_pkg::W-1:0] a,
  input  logic signed [akf_pkg::W-1:0] b,
  output logic                         done,
  output logic signed [akf_pkg::W-1:0] result
);
  import akf_pkg::*;

  localparam int PW = 2 * W;
  localparam int HW = W / 2;
  localparam logic [PW-1:0] RND = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] LAST_ACC = 3'd4;
  localparam logic [2:0] RND_STEP = 3'd5;
  localparam logic [2:0] SAT_STEP = 3'd6;

  logic [W-1:0]        am_r, bm_r;
  logic                neg_r;
  logic [PW-1:0]       acc_r;
  logic [W-1:0]        pp_r;
  logic [1:0]          psh_r;
  logic [2:0]          cnt_r;
  logic                busy_r, done_r;
  logic signed [W-1:0] res_r;

  logic [HW-1:0] a_seg, b_seg;
  logic [W-1:0]  pp_nxt;
  logic [PW-1:0] pp_ext, shifted;

  assign a_seg   = cnt_r[1] ? am_r[W-1:HW] : am_r[HW-1:0];
  assign b_seg   = cnt_r[0] ? bm_r[W-1:HW] : bm_r[HW-1:0];
  assign pp_nxt  = a_seg * b_seg;
  assign shifted = acc_r >> FRAC_BITS;

  always_comb begin
    case (psh_r)
      2'd0:    pp_ext = PW'(pp_r);
      2'd1:    pp_ext = PW'(pp_r) << HW;
      default: pp_ext = PW'(pp_r) << W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == SAT_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= mag48(a);
      bm_r  <= mag48(b);
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LAST_PP) begin
        pp_r  <= pp_nxt;
        psh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r != 3'd0 && cnt_r <= LAST_ACC) begin
        acc_r <= acc_r + pp_ext;
      end
      if (cnt_r == RND_STEP && neg_r) begin
        acc_r <= acc_r + RND;
      end
      if (cnt_r == SAT_STEP) begin
        res_r <= sat_mag(neg_r, |shifted[PW-1:W], shifted[W-1:0]);
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### src/akf_div.sv
// akf_div: bit-serial fixed-point divider, floor((n << FRAC_BITS) / s) for positive s
// depends on akf_pkg; one quotient bit per cycle, saturated to 48 bits
module akf_div #(
  parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [akf_pkg::W-1:0] n,
  input  logic signed [akf_pkg::W-1:0] s,
  output logic                         done,
  output logic signed [akf_pkg::W-1:0] result
);
  import akf_pkg::*;

  localparam int NB = W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]       num_r;
  logic [W-1:0]        rem_r, q_r, d_r;
  logic                over_r, neg_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0] rem_sh, rem_dif;
  logic         ge;
  logic [W:0]   q_fin;

  assign rem_sh  = {rem_r[W-2:0], num_r[NB-1]};
  assign ge      = rem_sh >= d_r;
  assign rem_dif = rem_sh - d_r;
  // negative quotients round toward minus infinity
  assign q_fin   = {1'b0, q_r} + (W+1)'(neg_r && (rem_r != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NB);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - CW'(1);
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {mag48(n), {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      d_r    <= s;
      neg_r  <= n[W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r  <= ge ? rem_dif : rem_sh;
        q_r    <= {q_r[W-2:0], ge};
        over_r <= over_r | q_r[W-1];
        num_r  <= num_r << 1;
      end else begin
        res_r <= sat_mag(neg_r, over_r | q_fin[W], q_fin[W-1:0]);
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### src/altitude_kalman_filter_6state.sv
// altitude_kalman_filter_6state: six-state constant-velocity kalman estimator, top level
// depends on akf_pkg, akf_in_if, akf_out_if, akf_mul and akf_div
//
// Takes one word at a time and returns one result word for each. The 6x6 covariance
// lives in a 36-entry synchronous memory (one write port, one read port, registered read
// data); the mean sits in six registers. A sequencer walks the covariance element by
// element: read the operand entry, read the target entry, multiply in the shared
// multiplier, write back. Writes land before the next element's first read, so no
// forwarding is needed. Work per word: init makes one memory write per entry; predict
// walks 45 elements, paced by the shared multiplier; update loads column z and row z,
// then takes six gains from the bit-serial divider, then walks 42 elements. A word whose
// kind is not known, or a predict or update before the first init, returns at once with
// status ignored. The input is taken only when the sequencer is idle; a finished result
// waits in the output register and the next word can be taken while it waits.
// Configuration writes go straight into the noise and variance registers and should be
// made only while the block is idle.
module altitude_kalman_filter_6state #(
  parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  akf_in_if.sink                            in_ch,
  akf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [akf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [akf_pkg::CFG_W-1:0]         cfg_data
);
  import akf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(N_ST - 1);
  localparam logic [IDX_W-1:0] LAST_P = IDX_W'(N_AX - 1);
  localparam logic [IDX_W-1:0] FIRST_V = IDX_W'(N_AX);
  localparam logic [3:0] LD_LAST = 4'(2 * N_ST);
  localparam logic [IDX_W-1:0] Z_IDX = IDX_W'(2);

  // configuration registers
  logic [CFG_W-1:0] pos_noise_r, vel_noise_r, alt_noise_r, init_var_r;

  // sequencer
  fsm_t   state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [3:0]       ld_r, ld_nxt;
  status_t          status_r, status_nxt;
  logic             tracker_ready_r;

  // latched word and working values
  logic [OP_W-1:0]     op_r;
  logic signed [W-1:0] accel_r [N_AX];
  logic [DT_W-1:0]     dt_r;
  logic signed [W-1:0] alt_r;
  logic signed [W-1:0] mean_r [N_ST];
  logic signed [W-1:0] col_r [N_ST];
  logic signed [W-1:0] row_r [N_ST];
  logic signed [W-1:0] gain_r [N_ST];
  logic signed [W-1:0] s_r, resid_r, m_r, x_r;

  // covariance store
  logic signed [W-1:0] cov_mem [COV_DEPTH];
  logic signed [W-1:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr, wr_addr, m_addr, x_addr;
  logic                mem_we;
  logic signed [W-1:0] mem_wdata;

  // output register
  logic                out_valid_r;
  logic signed [W-1:0] est_r [N_ST];
  logic [STAT_W-1:0]   out_status_r;
  logic                load_out;

  // arithmetic units
  logic                mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0] mul_a, mul_b, mul_res, div_res;

  logic                accept;
  logic signed [W-1:0] x_sel, sum1, addc, wb_res, dt_s;
  logic                mean_phase, cov_phase;
  logic [3:0]          ld_idx;
  logic [3:0]          ld_row;

  function automatic logic [ADDR_W-1:0] cov_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [ADDR_W-1:0] a;
    a = (ADDR_W'(r) << 2) + (ADDR_W'(r) << 1) + ADDR_W'(c);
    return a;
  endfunction

  akf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  akf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .n      (col_r[i_r]),
    .s      (s_r),
    .done   (div_done),
    .result (div_res)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign dt_s        = $signed(W'(dt_r));
  assign mean_phase  = (phase_r == PH_PMEAN) || (phase_r == PH_UMEAN);
  assign cov_phase   = !mean_phase;
  assign ld_idx      = ld_r - 4'd1;
  assign ld_row      = ld_r - 4'(N_ST);

  // operand addresses: the multiplicand entry and the entry being rewritten
  always_comb begin
    x_addr = cov_addr(i_r, j_r);
    case (phase_r)
      PH_COVA: m_addr = cov_addr(i_r + FIRST_V, j_r);
      PH_COVB: m_addr = cov_addr(i_r, j_r + FIRST_V);
      default: m_addr = cov_addr(i_r, j_r);
    endcase
  end

  // multiplier operands by phase
  always_comb begin
    case (phase_r)
      PH_PMEAN: begin
        mul_a = (i_r <= LAST_P) ? mean_r[i_r + FIRST_V] : accel_r[2'(i_r - FIRST_V)];
        mul_b = dt_s;
      end
      PH_COVA, PH_COVB: begin
        mul_a = m_r;
        mul_b = dt_s;
      end
      PH_UMEAN: begin
        mul_a = gain_r[i_r];
        mul_b = resid_r;
      end
      PH_UCOV: begin
        mul_a = gain_r[i_r];
        mul_b = row_r[j_r];
      end
      default: begin
        // velocity diagonal: noise only, product forced to zero
        mul_a = m_r;
        mul_b = '0;
      end
    endcase
  end

  // write-back value: saturate after the product, then again after the noise
  always_comb begin
    x_sel = mean_phase ? mean_r[i_r] : x_r;
    if (phase_r == PH_COVB && i_r == j_r) begin
      addc = $signed({1'b0, pos_noise_r});
    end else if (phase_r == PH_COVC) begin
      addc = $signed({1'b0, vel_noise_r});
    end else begin
      addc = '0;
    end
    sum1   = sat_add(x_sel, mul_res, phase_r == PH_UCOV);
    wb_res = sat_add(sum1, addc, 1'b0);
  end

  // next state and strobes
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ld_nxt     = ld_r;
    status_nxt = status_r;
    rd_addr    = x_addr;
    mem_we     = 1'b0;
    wr_addr    = x_addr;
    mem_wdata  = wb_res;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          i_nxt      = '0;
          j_nxt      = '0;
          ld_nxt     = '0;
          status_nxt = STAT_OK;
          case (in_ch.operation)
            OP_INIT: begin
              state_nxt = S_INIT;
            end
            OP_PREDICT: begin
              if (tracker_ready_r) begin
                phase_nxt = PH_PMEAN;
                state_nxt = S_EL_RDM;
              end else begin
                status_nxt = STAT_IGNORED;
                state_nxt  = S_FINISH;
              end
            end
            OP_UPDATE: begin
              if (tracker_ready_r) begin
                state_nxt = S_ULOAD;
              end else begin
                status_nxt = STAT_IGNORED;
                state_nxt  = S_FINISH;
              end
            end
            default: begin
              status_nxt = STAT_IGNORED;
              state_nxt  = S_FINISH;
            end
          endcase
        end
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (i_r == j_r) ? $signed({1'b0, init_var_r}) : '0;
        if (j_r == LAST_I) begin
          j_nxt = '0;
          if (i_r == LAST_I) begin
            state_nxt = S_FINISH;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_ULOAD: begin
        // column z first, then row z
        rd_addr = (ld_r < 4'(N_ST)) ? cov_addr(ld_r[IDX_W-1:0], Z_IDX)
                                    : cov_addr(Z_IDX, ld_row[IDX_W-1:0]);
        ld_nxt  = ld_r + 4'd1;
        if (ld_r == LD_LAST) begin
          state_nxt = S_USUM;
        end
      end
      S_USUM: begin
        state_nxt = S_UCHK;
      end
      S_UCHK: begin
        if (s_r[W-1] || s_r == '0) begin
          status_nxt = STAT_SKIPPED;
          state_nxt  = S_FINISH;
        end else begin
          i_nxt     = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (i_r == LAST_I) begin
            i_nxt     = '0;
            j_nxt     = '0;
            phase_nxt = PH_UMEAN;
            state_nxt = S_EL_RDM;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_EL_RDM: begin
        rd_addr   = m_addr;
        state_nxt = S_EL_RDX;
      end
      S_EL_RDX: begin
        rd_addr   = x_addr;
        state_nxt = S_EL_MUL;
      end
      S_EL_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_EL_WAIT;
      end
      S_EL_WAIT: begin
        if (mul_done) begin
          state_nxt = S_EL_WB;
        end
      end
      S_EL_WB: begin
        mem_we    = cov_phase;
        state_nxt = S_EL_RDM;
        case (phase_r)
          PH_PMEAN: begin
            if (i_r == LAST_I) begin
              phase_nxt = PH_COVA;
              i_nxt     = '0;
              j_nxt     = '0;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end
          PH_COVA: begin
            if (j_r == LAST_I) begin
              j_nxt = '0;
              if (i_r == LAST_P) begin
                phase_nxt = PH_COVB;
                i_nxt     = '0;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
          PH_COVB: begin
            if (j_r == LAST_P) begin
              j_nxt = '0;
              if (i_r == LAST_I) begin
                phase_nxt = PH_COVC;
                i_nxt     = FIRST_V;
                j_nxt     = FIRST_V;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
          PH_COVC: begin
            if (i_r == LAST_I) begin
              state_nxt = S_FINISH;
            end else begin
              i_nxt = i_r + IDX_W'(1);
              j_nxt = j_r + IDX_W'(1);
            end
          end
          PH_UMEAN: begin
            if (i_r == LAST_I) begin
              phase_nxt = PH_UCOV;
              i_nxt     = '0;
              j_nxt     = '0;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end
          PH_UCOV: begin
            if (j_r == LAST_I) begin
              j_nxt = '0;
              if (i_r == LAST_I) begin
                state_nxt = S_FINISH;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      phase_r         <= PH_PMEAN;
      i_r             <= '0;
      j_r             <= '0;
      ld_r            <= '0;
      status_r        <= STAT_OK;
      tracker_ready_r <= 1'b0;
      out_valid_r     <= 1'b0;
      pos_noise_r     <= POS_NOISE_RST;
      vel_noise_r     <= VEL_NOISE_RST;
      alt_noise_r     <= ALT_NOISE_RST;
      init_var_r      <= INIT_VAR_RST;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      ld_r     <= ld_nxt;
      status_r <= status_nxt;
      if (accept && in_ch.operation == OP_INIT) begin
        tracker_ready_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POS_NOISE: pos_noise_r <= cfg_data;
          REG_VEL_NOISE: vel_noise_r <= cfg_data;
          REG_ALT_NOISE: alt_noise_r <= cfg_data;
          REG_INIT_VAR:  init_var_r  <= cfg_data;
          default:       init_var_r  <= init_var_r;
        endcase
      end
    end
  end

  // covariance memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cov_mem[wr_addr] <= mem_wdata;
    end
    rd_data_r <= cov_mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_ch.operation;
      accel_r[0] <= in_ch.accel_x;
      accel_r[1] <= in_ch.accel_y;
      accel_r[2] <= in_ch.accel_z;
      dt_r       <= in_ch.time_step;
      alt_r      <= in_ch.altitude;
      if (in_ch.operation == OP_INIT) begin
        mean_r[0] <= in_ch.init_pos_x;
        mean_r[1] <= in_ch.init_pos_y;
        mean_r[2] <= in_ch.init_pos_z;
        mean_r[3] <= in_ch.init_vel_x;
        mean_r[4] <= in_ch.init_vel_y;
        mean_r[5] <= in_ch.init_vel_z;
      end
    end
    if (state_r == S_ULOAD && ld_r != '0) begin
      if (ld_idx < 4'(N_ST)) begin
        col_r[ld_idx[IDX_W-1:0]] <= rd_data_r;
      end else begin
        row_r[3'(ld_idx - 4'(N_ST))] <= rd_data_r;
      end
    end
    if (state_r == S_USUM) begin
      s_r     <= sat_add(col_r[Z_IDX], $signed({1'b0, alt_noise_r}), 1'b0);
      resid_r <= sat_add(alt_r, mean_r[Z_IDX], 1'b1);
    end
    if (state_r == S_DIV_WAIT && div_done) begin
      gain_r[i_r] <= div_res;
    end
    if (state_r == S_EL_RDX) begin
      m_r <= rd_data_r;
    end
    if (state_r == S_EL_MUL) begin
      x_r <= rd_data_r;
    end
    if (state_r == S_EL_WB && mean_phase) begin
      mean_r[i_r] <= wb_res;
    end
    if (load_out) begin
      for (int k = 0; k < N_ST; k++) begin
        est_r[k] <= tracker_ready_r ? mean_r[k] : '0;
      end
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.est_pos_x = est_r[0];
  assign out_ch.est_pos_y = est_r[1];
  assign out_ch.est_pos_z = est_r[2];
  assign out_ch.est_vel_x = est_r[3];
  assign out_ch.est_vel_y = est_r[4];
  assign out_ch.est_vel_z = est_r[5];
  assign out_ch.status    = out_status_r;

`ifndef NO_ASSERTIONS
  // the covariance store is only written by init or an element write-back
  a_mem_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_EL_WB))
    else $error("covariance write outside init or write-back");

  // a write-back always follows a finished product
  a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EL_WB |-> $past(mul_done))
    else $error("write-back without multiplier result");

  // a result appears only from the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result word raised outside finish");

  // once initialised the tracker stays ready
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tracker_ready_r |=> tracker_ready_r)
    else $error("tracker lost its initialised state");

  // a skipped status only comes from an update word
  a_skip_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && status_r == STAT_SKIPPED) |-> op_r == OP_UPDATE)
    else $error("skip status on a word that is not an update");
`endif

endmodule

### tb/tb_altitude_kalman_filter_6state.sv
// tb_altitude_kalman_filter_6state: self-checking testbench for the six-state kalman estimator
// depends on akf_pkg, akf_in_if, akf_out_if and the altitude_kalman_filter_6state top level
// a bit-exact predictor in a small scoreboard class checks every result word in order
`timescale 1ns / 1ps

module tb_altitude_kalman_filter_6state;
  import akf_pkg::*;

  typedef logic signed [W-1:0]   val_t;
  typedef logic signed [127:0]   wide_t;
  typedef logic [CFG_W-1:0]      cfg_t;

  // the two-bit operation field has one code that the block does not know
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int LONG_HOLD    = 3000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic [OP_W-1:0] operation;
    val_t            init_pos[3];
    val_t            init_vel[3];
    val_t            accel[3];
    logic [DT_W-1:0] time_step;
    val_t            altitude;
  } filter_word_t;

  typedef struct {
    val_t    est[6];
    status_t status;
  } estimate_t;

  // scoreboard: mirrors the filter state and queues the estimate each word should return
  class kalman_scoreboard;
    val_t      mean[6];
    val_t      cov[6][6];
    bit        tracking;
    cfg_t      pos_noise, vel_noise, alt_noise, init_var;
    estimate_t pending[$];
    int        errors, n_init, n_predict, n_update, n_skipped, n_ignored, n_checked;

    function new();
      tracking  = 0;
      pos_noise = POS_NOISE_RST;
      vel_noise = VEL_NOISE_RST;
      alt_noise = ALT_NOISE_RST;
      init_var  = INIT_VAR_RST;
    endfunction

    function val_t sat(wide_t v);
      wide_t hi, lo;
      hi = MAX48;
      lo = MIN48;
      if (v > hi) return MAX48;
      if (v < lo) return MIN48;
      return v[W-1:0];
    endfunction

    // product shifted down, rounded towards minus infinity
    function val_t mulq(val_t a, val_t b);
      wide_t wa, wb, p;
      wa = a;
      wb = b;
      p  = wa * wb;
      return sat(p >>> FRAC_BITS_DEF);
    endfunction

    function val_t divq(val_t n, val_t s);
      wide_t num, den, q;
      num = n;
      num = num <<< FRAC_BITS_DEF;
      den = s;
      q   = num / den;
      if (num < 0 && (num % den) != 0) q = q - 1;
      return sat(q);
    endfunction

    function val_t add_cfg(val_t a, cfg_t c);
      wide_t wa, wc;
      wa = a;
      wc = {1'b0, c};
      return sat(wa + wc);
    endfunction

    function val_t add(val_t a, val_t b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return sat(wa + wb);
    endfunction

    function void predict(filter_word_t w);
      val_t a[6][6];
      val_t dt, v;
      dt = {23'd0, w.time_step};
      for (int i = 0; i < 3; i++) begin
        v           = mean[i+3];
        mean[i]     = add(mean[i], mulq(v, dt));
        mean[i+3]   = add(v, mulq(w.accel[i], dt));
      end
      for (int i = 0; i < 6; i++)
        for (int j = 0; j < 6; j++)
          a[i][j] = (i < 3) ? add(cov[i][j], mulq(dt, cov[i+3][j])) : cov[i][j];
      for (int i = 0; i < 6; i++)
        for (int j = 0; j < 6; j++)
          cov[i][j] = (j < 3) ? add(a[i][j], mulq(a[i][j+3], dt)) : a[i][j];
      for (int i = 0; i < 6; i++)
        cov[i][i] = add_cfg(cov[i][i], (i < 3) ? pos_noise : vel_noise);
    endfunction

    function status_t update(filter_word_t w);
      val_t s, resid;
      val_t gain[6], row[6];
      wide_t wa, wb;
      s = add_cfg(cov[2][2], alt_noise);
      if (s <= 0) return STAT_SKIPPED;
      wa    = w.altitude;
      wb    = mean[2];
      resid = sat(wa - wb);
      for (int i = 0; i < 6; i++) begin
        gain[i] = divq(cov[i][2], s);
        row[i]  = cov[2][i];
      end
      for (int i = 0; i < 6; i++) begin
        mean[i] = add(mean[i], mulq(gain[i], resid));
        for (int j = 0; j < 6; j++) begin
          wa        = cov[i][j];
          wb        = mulq(gain[i], row[j]);
          cov[i][j] = sat(wa - wb);
        end
      end
      return STAT_OK;
    endfunction

    // accepted input word: advance the mirror and queue its estimate
    function void note_word(filter_word_t w);
      estimate_t e;
      e.status = STAT_IGNORED;
      if (w.operation == OP_INIT) begin
        for (int i = 0; i < 3; i++) begin
          mean[i]   = w.init_pos[i];
          mean[i+3] = w.init_vel[i];
        end
        for (int i = 0; i < 6; i++)
          for (int j = 0; j < 6; j++)
            cov[i][j] = (i == j) ? val_t'({1'b0, init_var}) : '0;
        tracking = 1;
        e.status = STAT_OK;
        n_init++;
      end else if (w.operation == OP_PREDICT && tracking) begin
        predict(w);
        e.status = STAT_OK;
        n_predict++;
      end else if (w.operation == OP_UPDATE && tracking) begin
        e.status = update(w);
        if (e.status == STAT_SKIPPED) n_skipped++;
        else n_update++;
      end else begin
        n_ignored++;
      end
      for (int i = 0; i < 6; i++) e.est[i] = tracking ? mean[i] : '0;
      pending.push_back(e);
    endfunction

    function void cmp(string name, val_t exp_v, val_t act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_estimate(estimate_t r);
      estimate_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      cmp("est_pos_x", e.est[0], r.est[0]);
      cmp("est_pos_y", e.est[1], r.est[1]);
      cmp("est_pos_z", e.est[2], r.est[2]);
      cmp("est_vel_x", e.est[3], r.est[3]);
      cmp("est_vel_y", e.est[4], r.est[4]);
      cmp("est_vel_z", e.est[5], r.est[5]);
      if (e.status !== r.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, r.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  akf_in_if  in_ch();
  akf_out_if out_ch();

  altitude_kalman_filter_6state i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kalman_scoreboard sb = new();

  int  burst_left = 0;
  bit  hold_request = 0;   // asks the receiver for one long stall

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // generous cycle limit so a hung block cannot run forever
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  // receiver: checks accepted words and stalls in its own pattern
  initial begin
    estimate_t r;
    int mode, mode_left, hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        r.est[0] = out_ch.est_pos_x;
        r.est[1] = out_ch.est_pos_y;
        r.est[2] = out_ch.est_pos_z;
        r.est[3] = out_ch.est_vel_x;
        r.est[4] = out_ch.est_vel_y;
        r.est[5] = out_ch.est_vel_z;
        r.status = status_t'(out_ch.status);
        sb.check_estimate(r);
      end
      if (hold_request && hold_left == 0) begin
        hold_left    = LONG_HOLD;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        // long hold-off: the result register fills and the input stalls
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic val_t rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    // a fifth full range, the rest within 128 metres
    if ($urandom_range(0, 4) == 0) return r[W-1:0];
    return val_t'($signed(r[31:0])) >>> $urandom_range(0, 8);
  endfunction

  function automatic filter_word_t rand_word();
    filter_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) w.operation = OP_INIT;
    else if (pick < 52) w.operation = OP_PREDICT;
    else if (pick < 96) w.operation = OP_UPDATE;
    else w.operation = OP_RESERVED;
    for (int i = 0; i < 3; i++) begin
      w.init_pos[i] = rand_val();
      w.init_vel[i] = rand_val();
      w.accel[i]    = rand_val();
    end
    // mostly short steps, now and then the full unsigned range
    if ($urandom_range(0, 9) == 0) w.time_step = DT_W'($urandom);
    else w.time_step = DT_W'($urandom_range(0, 1677722));
    w.altitude = rand_val();
    return w;
  endfunction

  function automatic filter_word_t make_word(logic [OP_W-1:0] op, val_t v,
                                             logic [DT_W-1:0] dt);
    filter_word_t w;
    w.operation = op;
    for (int i = 0; i < 3; i++) begin
      w.init_pos[i] = v;
      w.init_vel[i] = (i == 1) ? -v : v;
      w.accel[i]    = v;
    end
    w.time_step = dt;
    w.altitude  = v;
    return w;
  endfunction

  // write all four registers back to back while the block is idle
  task automatic write_regs(cfg_t pos_n, cfg_t vel_n, cfg_t alt_n, cfg_t ivar);
    cfg_t vals[4];
    vals = '{pos_n, vel_n, alt_n, ivar};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(cfg_idx_t'(i));
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.pos_noise = pos_n;
    sb.vel_noise = vel_n;
    sb.alt_noise = alt_n;
    sb.init_var  = ivar;
  endtask

  // offer one word, wait for the handshake, then maybe leave a gap
  task automatic send_word(filter_word_t w);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= w.operation;
    in_ch.init_pos_x <= w.init_pos[0];
    in_ch.init_pos_y <= w.init_pos[1];
    in_ch.init_pos_z <= w.init_pos[2];
    in_ch.init_vel_x <= w.init_vel[0];
    in_ch.init_vel_y <= w.init_vel[1];
    in_ch.init_vel_z <= w.init_vel[2];
    in_ch.accel_x    <= w.accel[0];
    in_ch.accel_y    <= w.accel[1];
    in_ch.accel_z    <= w.accel[2];
    in_ch.time_step  <= w.time_step;
    in_ch.altitude   <= w.altitude;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // idle between phases: nothing expected, then a short pause
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) send_word(rand_word());
  endtask

  initial begin
    cfg_t max_cfg;
    val_t small_v;
    max_cfg = '1;
    small_v = 48'sd16777216;   // one metre
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.operation = OP_INIT;
    in_ch.init_pos_x = '0;
    in_ch.init_pos_y = '0;
    in_ch.init_pos_z = '0;
    in_ch.init_vel_x = '0;
    in_ch.init_vel_y = '0;
    in_ch.init_vel_z = '0;
    in_ch.accel_x  = '0;
    in_ch.accel_y  = '0;
    in_ch.accel_z  = '0;
    in_ch.time_step = '0;
    in_ch.altitude = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, words before the first init, then field extremes
    send_word(make_word(OP_PREDICT, small_v, 25'd1677722));
    send_word(make_word(OP_UPDATE, small_v, '0));
    send_word(make_word(OP_RESERVED, small_v, '0));
    send_word(make_word(OP_INIT, MAX48, '0));
    send_word(make_word(OP_PREDICT, MAX48, '1));       // step beyond one second
    send_word(make_word(OP_UPDATE, MIN48, '0));
    send_word(make_word(OP_INIT, MIN48, '0));
    send_word(make_word(OP_PREDICT, MIN48, 25'd16777216));
    send_word(make_word(OP_UPDATE, MAX48, '0));
    send_word(make_word(OP_INIT, small_v, '0));
    send_word(make_word(OP_PREDICT, small_v, '0));     // zero step
    send_word(make_word(OP_PREDICT, -small_v, 25'd1677722));
    send_word(make_word(OP_UPDATE, small_v, '0));
    send_word(make_word(OP_RESERVED, -small_v, '1));
    send_word(make_word(OP_UPDATE, -small_v, '0));
    wait_idle();

    // zero noise and zero variance: the innovation variance is zero, update skipped
    write_regs('0, '0, '0, '0);
    send_word(make_word(OP_INIT, small_v, '0));
    send_word(make_word(OP_UPDATE, -small_v, '0));
    send_word(make_word(OP_PREDICT, small_v, 25'd8388608));
    send_word(make_word(OP_UPDATE, small_v, '0));
    wait_idle();

    // all registers at their maximum
    write_regs(max_cfg, max_cfg, max_cfg, max_cfg);
    send_word(make_word(OP_INIT, small_v, '0));
    random_words(80);
    wait_idle();

    // realistic settings, with one long receiver hold-off part way through
    write_regs(47'd167772, 47'd1677722, 47'd33554432, 47'd1677722);
    send_word(make_word(OP_INIT, small_v, '0));
    random_words(150);
    hold_request = 1;
    random_words(150);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        write_regs(cfg_t'({$urandom, $urandom}), cfg_t'({$urandom, $urandom}),
                   cfg_t'({$urandom, $urandom}), cfg_t'({$urandom, $urandom}));
      end else begin
        write_regs(cfg_t'($urandom_range(0, 1 << 24)), cfg_t'($urandom_range(0, 1 << 26)),
                   cfg_t'($urandom_range(0, 1 << 28)), cfg_t'($urandom_range(0, 1 << 26)));
      end
      send_word(rand_word());
      send_word(make_word(OP_INIT, rand_val(), '0));
      random_words(190);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inits, %0d predicts, %0d updates, %0d skipped updates,",
             sb.n_init, sb.n_predict, sb.n_update, sb.n_skipped);
    $display("%0d ignored words; %0d results checked over eight register settings",
             sb.n_ignored, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
